/* design/sidta_pkg.sv */
package sidta_pkg;

  localparam int RADIX = 10;

  // ASCII codes of the emitted characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Magnitude bits folded into the BCD register per conversion cycle
  localparam int DD_STEP = 4;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } bk_state_t;

  // Decimal digits needed for the largest magnitude, 2^(bits-1)
  function automatic int num_digits(input int bits);
    longint unsigned v;
    int              n;
    v = 64'd1 << (bits - 1);
    n = 0;
    while (v != 0) begin
      v = v / RADIX;
      n++;
    end
    return n;
  endfunction

endpackage

/* design/sidta_front.sv */
module sidta_front #(
  parameter int VALUE_BITS = 32,
  parameter int InW        = 32,
  parameter int NDig       = 10,
  parameter int IdxW       = 4,
  parameter int QW         = 1 + IdxW + 4 * NDig
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [InW-1:0] in_tdata,
  output logic           q_valid,
  input  logic           q_ready,
  output logic [QW-1:0]  q_data
);

  localparam int MagW    = ((VALUE_BITS + sidta_pkg::DD_STEP - 1) / sidta_pkg::DD_STEP)
                           * sidta_pkg::DD_STEP;
  localparam int ConvCyc = MagW / sidta_pkg::DD_STEP;
  localparam int CntW    = (ConvCyc > 1) ? $clog2(ConvCyc) : 1;
  localparam int AccW    = 4 * NDig + MagW;

  sidta_pkg::fe_state_t state_r, state_nxt;

  logic [CntW-1:0]          cnt_r, cnt_nxt;
  logic                     neg_r, neg_nxt;
  logic [MagW-1:0]          mag_r, mag_nxt;
  logic [NDig-1:0][3:0]     bcd_r, bcd_nxt;

  logic [VALUE_BITS-1:0]    raw;
  logic [VALUE_BITS-1:0]    mag_in;
  logic [AccW-1:0]          acc;
  logic [NDig-1:0][3:0]     dig_v;
  logic [IdxW-1:0]          top;

  assign raw    = in_tdata[VALUE_BITS-1:0];
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // Shift-and-add-3 over DD_STEP magnitude bits
  always_comb begin
    acc = {bcd_r, mag_r};
    for (int s = 0; s < sidta_pkg::DD_STEP; s++) begin
      dig_v = acc[AccW-1:MagW];
      for (int d = 0; d < NDig; d++) begin
        if (dig_v[d] >= 4'd5) begin
          dig_v[d] = dig_v[d] + 4'd3;
        end
      end
      acc = {dig_v, acc[MagW-1:0]} << 1;
    end
  end

  // Highest nonzero digit, zero when the value is zero
  always_comb begin
    top = '0;
    for (int d = 1; d < NDig; d++) begin
      if (bcd_r[d] != 4'd0) begin
        top = IdxW'(d);
      end
    end
  end

  assign q_data = {neg_r, top, bcd_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    in_tready = 1'b0;
    q_valid   = 1'b0;
    unique case (state_r)
      sidta_pkg::FE_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          neg_nxt   = raw[VALUE_BITS-1];
          mag_nxt   = MagW'(mag_in);
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = sidta_pkg::FE_CONV;
        end
      end
      sidta_pkg::FE_CONV: begin
        bcd_nxt = acc[AccW-1:MagW];
        mag_nxt = acc[MagW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(ConvCyc - 1)) begin
          state_nxt = sidta_pkg::FE_PUSH;
        end
      end
      sidta_pkg::FE_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_nxt = sidta_pkg::FE_IDLE;
        end
      end
      default: state_nxt = sidta_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sidta_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

endmodule

/* design/sidta_queue.sv */
module sidta_queue #(
  parameter int W = 45
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int Depth = sidta_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [W-1:0]    mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign wr_ready = (cnt_r != CntW'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/sidta_back.sv */
module sidta_back #(
  parameter int NDig = 10,
  parameter int IdxW = 4,
  parameter int QW   = 1 + IdxW + 4 * NDig
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  sidta_pkg::bk_state_t state_r, state_nxt;

  logic [IdxW-1:0]      pos_r, pos_nxt;
  logic [NDig-1:0][3:0] dig_r, dig_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_ch_r, out_ch_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 load_ok;
  logic                 take;
  logic                 q_neg;
  logic [IdxW-1:0]      q_top;
  logic [NDig-1:0][3:0] q_dig;

  assign {q_neg, q_top, q_dig} = q_data;
  assign load_ok = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;
    q_ready       = 1'b0;
    take          = 1'b0;
    unique case (state_r)
      sidta_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        take    = q_valid;
      end
      sidta_pkg::BK_SIGN: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = sidta_pkg::CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = sidta_pkg::BK_DIGIT;
        end
      end
      sidta_pkg::BK_DIGIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = sidta_pkg::CH_ZERO + {4'd0, dig_r[pos_r]};
          out_last_nxt  = (pos_r == '0);
          if (pos_r == '0) begin
            // pick up the next request on the final character
            q_ready   = 1'b1;
            take      = q_valid;
            state_nxt = sidta_pkg::BK_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: state_nxt = sidta_pkg::BK_IDLE;
    endcase
    if (take) begin
      pos_nxt   = q_top;
      dig_nxt   = q_dig;
      state_nxt = q_neg ? sidta_pkg::BK_SIGN : sidta_pkg::BK_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sidta_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    dig_r      <= dig_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ch_r;
  assign out_tlast  = out_last_r;

endmodule

/* design/signed_int_to_decimal_ascii.sv */
// Signed integer to decimal ASCII text.
//
// Input stream (in_*): one request per number; in_tdata carries the signed
// VALUE_BITS-bit value in its low bits, upper pad bits are ignored.
// Output stream (out_*): one ASCII character per transfer, most significant
// first: '-' for negative values, then the digits with no leading zeros.
// out_tlast marks the final character of each number.
//
// The front converts the magnitude with shift-and-add-3, four bits per
// cycle. A two-entry queue feeds the back, which emits one character per
// cycle while the receiver does not stall, so the front can convert the
// next number while the back is still emitting the last one.
// While the receiver stalls, the output register holds its character and
// the front keeps converting until the queue is full.
// Reset empties the queue and drops any conversion and character in flight.
module signed_int_to_decimal_ascii #(
  parameter  int VALUE_BITS = 32,
  localparam int InW        = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [InW-1:0] in_tdata,    // [VALUE_BITS-1:0] value, rest zero pad
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,   // [7:0] ch
  output logic           out_tlast    // last
);

  localparam int NDig = sidta_pkg::num_digits(VALUE_BITS);
  localparam int IdxW = (NDig > 1) ? $clog2(NDig) : 1;
  localparam int QW   = 1 + IdxW + 4 * NDig;

  logic          fq_valid, fq_ready;
  logic [QW-1:0] fq_data;
  logic          qb_valid, qb_ready;
  logic [QW-1:0] qb_data;

  sidta_front #(
    .VALUE_BITS (VALUE_BITS),
    .InW        (InW),
    .NDig       (NDig),
    .IdxW       (IdxW),
    .QW         (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  sidta_queue #(
    .W (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  sidta_back #(
    .NDig (NDig),
    .IdxW (IdxW),
    .QW   (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/sidta_checker.sv */
module sidta_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output character changed");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= sidta_pkg::CH_ZERO && out_tdata <= 8'h39) ||
                   (out_tdata == sidta_pkg::CH_MINUS))
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == sidta_pkg::CH_MINUS |-> !out_tlast)
    else $error("minus sign closes a number");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
